// File: hw/rtl/saturated_formation_control_law_defines.svh
// Assertion macros shared by the checking code of the formation control law
`ifndef SATURATED_FORMATION_CONTROL_LAW_DEFINES_SVH
`define SATURATED_FORMATION_CONTROL_LAW_DEFINES_SVH

// same-cycle implication, sampled on clock, masked during reset
`define SFCL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, masked during reset
`define SFCL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sfcl_pkg.sv
// Types, constants and helper functions of the formation control law
`default_nettype none
package sfcl_pkg;

   localparam int POS_FIELDS = 3;
   localparam int DIFF_W     = 18;
   localparam int SUM_W      = 21;
   localparam int GAIN_W     = 21;
   localparam int LIMIT_W    = 17;
   localparam int CSR_DATA_W = 21;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FORMATION_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LIMIT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_LIMIT    = 2'd3;

   localparam logic signed [GAIN_W-1:0] GAIN_MAX = 21'sd655360;
   localparam logic signed [63:0] Q32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] Q32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [2:0]         agent_index;
      logic signed [31:0] position_0;
      logic signed [31:0] position_1;
      logic signed [31:0] position_2;
      logic signed [31:0] velocity;
      logic signed [31:0] reference_velocity;
   } req_payload_type;

   typedef struct packed {
      logic signed [17:0] drive;
      logic               index_error;
   } rsp_payload_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > Q32_MAX) begin
         r = Q32_MAX[31:0];
      end else if (v < Q32_MIN) begin
         r = Q32_MIN[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [GAIN_W-1:0] clamp_gain(
      input logic signed [GAIN_W-1:0] g);
      logic signed [GAIN_W-1:0] r;
      if (g > GAIN_MAX) begin
         r = GAIN_MAX;
      end else if (g < -GAIN_MAX) begin
         r = -GAIN_MAX;
      end else begin
         r = g;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/saturated_formation_control_law.sv
// Top level of the saturated consensus formation control law
//
// Request channel (req_valid/req_ready/req_payload): one beat carries the agent
// index, the three position samples, the velocity and the reference velocity.
// Response channel (rsp_valid/rsp_ready/rsp_payload): one beat per request with
// the clamped drive value and the index error flag.
// Configuration: csr_write_enable writes csr_write_data to the register picked
// by csr_index (formation gain, velocity gain, output limit, error limit); gains
// are saturated to plus or minus ten on write. Write only while the block is idle.
// A request beat passes the lane, merge, product and result registers in turn.
// Throughput: one beat per cycle unless stalled; AGENT_COUNT lanes form position
// errors in parallel, a merge stage sums them, then one multiplier per gain term.
// Reset clears the configuration registers and empties the pipeline.
// When the receiver stalls, empty stages still fill; req_ready drops only once
// every stage holds a beat, and the waiting response holds unchanged.
`default_nettype none
module saturated_formation_control_law #(
   parameter int AGENT_COUNT = 3
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire sfcl_pkg::req_payload_type             req_payload,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output sfcl_pkg::rsp_payload_type                  rsp_payload,
   input  wire logic                                  csr_write_enable,
   input  wire logic [sfcl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [sfcl_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import sfcl_pkg::*;

   logic signed [GAIN_W-1:0]  formation_gain_ff, formation_gain_in;
   logic signed [GAIN_W-1:0]  velocity_gain_ff, velocity_gain_in;
   logic [LIMIT_W-1:0]        output_limit_ff, output_limit_in;
   logic [LIMIT_W-1:0]        error_limit_ff, error_limit_in;

   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic enable1, enable2, enable3, enable4;

   logic signed [31:0] positions [POS_FIELDS];
   logic signed [31:0] own_position;
   logic signed [32:0] vel_delta;
   logic signed [31:0] vel_error_in;
   logic signed [31:0] vel_error1_ff, vel_error2_ff;
   logic               index_error_in, index_error1_ff, index_error2_ff;

   logic [AGENT_COUNT-1:0][DIFF_W-1:0] lane_diff;
   logic signed [SUM_W-1:0]            error_sum;

   always_comb begin
      formation_gain_in = formation_gain_ff;
      velocity_gain_in  = velocity_gain_ff;
      output_limit_in   = output_limit_ff;
      error_limit_in    = error_limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FORMATION_GAIN: formation_gain_in = clamp_gain($signed(csr_write_data));
            CSR_VELOCITY_GAIN:  velocity_gain_in  = clamp_gain($signed(csr_write_data));
            CSR_OUTPUT_LIMIT:   output_limit_in   = csr_write_data[LIMIT_W-1:0];
            CSR_ERROR_LIMIT:    error_limit_in    = csr_write_data[LIMIT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         formation_gain_ff <= '0;
         velocity_gain_ff  <= '0;
         output_limit_ff   <= '0;
         error_limit_ff    <= '0;
      end else begin
         formation_gain_ff <= formation_gain_in;
         velocity_gain_ff  <= velocity_gain_in;
         output_limit_ff   <= output_limit_in;
         error_limit_ff    <= error_limit_in;
      end
   end

   // advance a stage when it is empty or its successor advances
   assign enable4   = !valid4_ff || rsp_ready;
   assign enable3   = !valid3_ff || enable4;
   assign enable2   = !valid2_ff || enable3;
   assign enable1   = !valid1_ff || enable2;
   assign req_ready = enable1;
   assign rsp_valid = valid4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (enable1) valid1_ff <= req_valid;
         if (enable2) valid2_ff <= valid1_ff;
         if (enable3) valid3_ff <= valid2_ff;
         if (enable4) valid4_ff <= valid3_ff;
      end
   end

   always_comb begin
      positions[0] = req_payload.position_0;
      positions[1] = req_payload.position_1;
      positions[2] = req_payload.position_2;
      case (req_payload.agent_index)
         3'd0:    own_position = req_payload.position_0;
         3'd1:    own_position = req_payload.position_1;
         3'd2:    own_position = req_payload.position_2;
         default: own_position = '0;
      endcase
      index_error_in = ({1'b0, req_payload.agent_index} >= 4'(AGENT_COUNT));
      vel_delta      = {req_payload.velocity[31], req_payload.velocity}
                     - {req_payload.reference_velocity[31], req_payload.reference_velocity};
      vel_error_in   = sat32($signed({{31{vel_delta[32]}}, vel_delta}));
   end

   always_ff @(posedge clock) begin
      if (enable1) begin
         vel_error1_ff   <= vel_error_in;
         index_error1_ff <= index_error_in;
      end
      if (enable2) begin
         vel_error2_ff   <= vel_error1_ff;
         index_error2_ff <= index_error1_ff;
      end
   end

   for (genvar j = 0; j < AGENT_COUNT; j++) begin : g_lane
      logic signed [31:0] other_position;
      if (j < POS_FIELDS) begin : g_field
         assign other_position = positions[j];
      end else begin : g_zero
         assign other_position = '0;
      end
      sfcl_lane u_lane (
         .clock          (clock),
         .enable         (enable1),
         .own_position   (own_position),
         .other_position (other_position),
         .error_limit    (error_limit_ff),
         .diff_ff        (lane_diff[j])
      );
   end

   sfcl_merge #(
      .LANE_COUNT (AGENT_COUNT)
   ) u_merge (
      .clock     (clock),
      .enable    (enable2),
      .lane_diff (lane_diff),
      .sum_ff    (error_sum)
   );

   sfcl_law u_law (
      .clock          (clock),
      .product_enable (enable3),
      .result_enable  (enable4),
      .formation_gain (formation_gain_ff),
      .velocity_gain  (velocity_gain_ff),
      .output_limit   (output_limit_ff),
      .error_sum      (error_sum),
      .velocity_error (vel_error2_ff),
      .index_error    (index_error2_ff),
      .result_ff      (rsp_payload)
   );

endmodule
`default_nettype wire

// File: hw/rtl/sfcl_lane.sv
// One lane: clamped relative position error against one agent
`default_nettype none
module sfcl_lane (
   input  wire logic                                clock,
   input  wire logic                                enable,
   input  wire logic signed [31:0]                  own_position,
   input  wire logic signed [31:0]                  other_position,
   input  wire logic [sfcl_pkg::LIMIT_W-1:0]        error_limit,
   output logic signed [sfcl_pkg::DIFF_W-1:0]       diff_ff
);
   import sfcl_pkg::*;

   logic signed [32:0]       delta;
   logic signed [32:0]       limit_pos;
   logic signed [32:0]       clamped;
   logic signed [DIFF_W-1:0] diff_in;

   always_comb begin
      delta     = {own_position[31], own_position} - {other_position[31], other_position};
      limit_pos = $signed({16'b0, error_limit});
      if (delta > limit_pos) begin
         clamped = limit_pos;
      end else if (delta < -limit_pos) begin
         clamped = -limit_pos;
      end else begin
         clamped = delta;
      end
      diff_in = clamped[DIFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff <= diff_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/sfcl_merge.sv
// Merge stage: sums the clamped errors of all lanes
`default_nettype none
module sfcl_merge #(
   parameter int LANE_COUNT = 3
) (
   input  wire logic                                         clock,
   input  wire logic                                         enable,
   input  wire logic [LANE_COUNT-1:0][sfcl_pkg::DIFF_W-1:0]  lane_diff,
   output logic signed [sfcl_pkg::SUM_W-1:0]                 sum_ff
);
   import sfcl_pkg::*;

   logic signed [SUM_W-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANE_COUNT; i++) begin
         sum_in = sum_in + $signed({{(SUM_W-DIFF_W){lane_diff[i][DIFF_W-1]}}, lane_diff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sum_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/sfcl_law.sv
// Gain products, saturation and output clamp of the control law
`default_nettype none
module sfcl_law (
   input  wire logic                                 clock,
   input  wire logic                                 product_enable,
   input  wire logic                                 result_enable,
   input  wire logic signed [sfcl_pkg::GAIN_W-1:0]   formation_gain,
   input  wire logic signed [sfcl_pkg::GAIN_W-1:0]   velocity_gain,
   input  wire logic [sfcl_pkg::LIMIT_W-1:0]         output_limit,
   input  wire logic signed [sfcl_pkg::SUM_W-1:0]    error_sum,
   input  wire logic signed [31:0]                   velocity_error,
   input  wire logic                                 index_error,
   output sfcl_pkg::rsp_payload_type                 result_ff
);
   import sfcl_pkg::*;

   logic signed [41:0] form_product_ff;
   logic signed [41:0] form_product_in;
   logic signed [52:0] vel_product_ff;
   logic signed [52:0] vel_product_in;
   logic               index_error_ff;

   logic signed [42:0] form_negated;
   logic signed [31:0] form_term;
   logic signed [31:0] vel_term;
   logic signed [32:0] total_wide;
   logic signed [31:0] total;
   logic signed [31:0] limit_pos;
   logic signed [31:0] clamped;
   rsp_payload_type    result_in;

   assign form_product_in = formation_gain * error_sum;
   assign vel_product_in  = velocity_gain * velocity_error;

   always_ff @(posedge clock) begin
      if (product_enable) begin
         form_product_ff <= form_product_in;
         vel_product_ff  <= vel_product_in;
         index_error_ff  <= index_error;
      end
   end

   always_comb begin
      form_negated = -$signed({form_product_ff[41], form_product_ff});
      form_term    = sat32($signed({{37{form_negated[42]}}, form_negated[42:16]}));
      vel_term     = sat32($signed({{27{vel_product_ff[52]}}, vel_product_ff[52:16]}));
      total_wide   = {form_term[31], form_term} + {vel_term[31], vel_term};
      total        = sat32($signed({{31{total_wide[32]}}, total_wide}));
      limit_pos    = $signed({15'b0, output_limit});
      if (total > limit_pos) begin
         clamped = limit_pos;
      end else if (total < -limit_pos) begin
         clamped = -limit_pos;
      end else begin
         clamped = total;
      end
      result_in.index_error = index_error_ff;
      result_in.drive       = index_error_ff ? '0 : clamped[17:0];
   end

   always_ff @(posedge clock) begin
      if (result_enable) begin
         result_ff <= result_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/sfcl_checker.sv
// Port-level checks of the formation control law and their binding
`default_nettype none
`include "saturated_formation_control_law_defines.svh"
module sfcl_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire sfcl_pkg::rsp_payload_type  rsp_payload
);
   import sfcl_pkg::*;

   `SFCL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response beat dropped or changed while stalled")
   `SFCL_ASSERT_NOW(a_index_zero, rsp_valid && rsp_payload.index_error, rsp_payload.drive == '0, "index error with non-zero drive")
   `SFCL_ASSERT_NOW(a_ready_full, !req_ready, rsp_valid && !rsp_ready, "request refused while the output side can move")

endmodule

bind saturated_formation_control_law sfcl_checker u_sfcl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
